/* src/sdc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sdc_pkg;

  localparam int unsigned MAX_BLOCK_LEN = 4096;
  localparam int unsigned FRAME_LEN     = 6;
  localparam int unsigned CNT_W         = 13;
  localparam int unsigned BLK_W         = 13;
  localparam int unsigned ARG_BYTES     = FRAME_LEN - 1;
  localparam int unsigned FIDX_W        = $clog2(ARG_BYTES);

  localparam logic [7:0] START_MASK = 8'hC0;
  localparam logic [7:0] START_CODE = 8'h40;
  localparam logic [7:0] DATA_TOKEN = 8'hFE;
  localparam logic [7:0] IDLE_BYTE  = 8'hFF;
  localparam logic [7:0] R1_IDLE    = 8'h01;
  localparam logic [7:0] R1_READY   = 8'h00;
  localparam logic [7:0] CMD_MASK   = 8'h3F;

  localparam logic [BLK_W-1:0] BLK_LEN_RST = BLK_W'(512);

  typedef enum logic [5:0] {
    CMD_GO_IDLE    = 6'd0,
    CMD_SEND_OP    = 6'd1,
    CMD_STOP       = 6'd12,
    CMD_SET_BLEN   = 6'd16,
    CMD_READ_MULTI = 6'd18
  } cmd_e;

  typedef enum logic [1:0] {
    ADDR_DATA   = 2'd0,
    ADDR_XFER   = 2'd1,
    ADDR_CS_ON  = 2'd2,
    ADDR_CS_OFF = 2'd3
  } addr_e;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_COMMAND   = 5'b00010,
    PH_RESPONSE  = 5'b00100,
    PH_READ_RESP = 5'b01000,
    PH_READ      = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0]  rdata;
    logic [31:0] read_pointer;
    logic        byte_consumed;
  } rsp_t;

endpackage

`default_nettype wire

/* src/sdc_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface sdc_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [1:0] addr;
  logic [7:0] wdata;
  logic [7:0] image_byte;

  modport source (output valid, req_type, addr, wdata, image_byte, input ready);
  modport sink   (input valid, req_type, addr, wdata, image_byte, output ready);
endinterface

interface sdc_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rdata;
  logic [31:0] read_pointer;
  logic        byte_consumed;

  modport source (output valid, rdata, read_pointer, byte_consumed, input ready);
  modport sink   (input valid, rdata, read_pointer, byte_consumed, output ready);
endinterface

`default_nettype wire

/* src/sd_card_spi_byte_engine_core.sv */
// Channel | Dir | Fields                                    | Beat
// req_i   | in  | req_type, addr, wdata, image_byte         | one bus access
// rsp_o   | out | rdata, read_pointer, byte_consumed        | one result per access
//
// Each access is handled in the cycle it is accepted; one access per cycle sustained while rsp_o keeps taking results.
// Card state updates at the accepting edge; the result lands in a two-entry output buffer.
// req_i.ready drops only while both output entries are full (rsp_o stalled).
// Async active-low reset: card idle, deselected, block length 512, pointer 0.
`timescale 1ns / 1ps
`default_nettype none

module sd_card_spi_byte_engine_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sdc_req_if.sink   req_i,
  sdc_rsp_if.source rsp_o
);
  import sdc_pkg::*;

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [BLK_W-1:0] blen_q, blen_d;
  logic [31:0]      ptr_q, ptr_d;
  logic [7:0]       resp_q, resp_d;
  logic [7:0]       send_q, send_d;
  logic [7:0]       recv_q, recv_d;
  logic             sel_q, sel_d;
  logic [7:0]       frame_q [ARG_BYTES];

  logic              accept, xfer, start, run;
  logic              frame_we;
  logic [FIDX_W-1:0] frame_idx;
  logic [7:0]        xout;
  logic [31:0]       arg;
  logic [5:0]        cmd;
  rsp_t              rsp_d;
  logic              buf_ready;

  assign accept = req_i.valid && req_i.ready;
  assign xfer   = req_i.req_type && (addr_e'(req_i.addr) == ADDR_XFER);
  assign start  = (send_q & START_MASK) == START_CODE;
  assign cmd    = 6'(frame_q[0] & CMD_MASK);
  assign arg    = {frame_q[1], frame_q[2], frame_q[3], frame_q[4]};

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    blen_d    = blen_q;
    ptr_d     = ptr_q;
    resp_d    = resp_q;
    send_d    = send_q;
    recv_d    = recv_q;
    sel_d     = sel_q;
    xout      = IDLE_BYTE;
    frame_we  = 1'b0;
    frame_idx = '0;
    run       = 1'b0;
    rsp_d.rdata         = IDLE_BYTE;
    rsp_d.byte_consumed = 1'b0;

    if (xfer && sel_q) begin
      unique case (phase_q)
        PH_COMMAND: begin
          cnt_d = cnt_q + CNT_W'(1);
          if (cnt_q < CNT_W'(ARG_BYTES)) begin
            frame_we  = 1'b1;
            frame_idx = cnt_q[FIDX_W-1:0];
          end
          if (cnt_q == CNT_W'(FRAME_LEN - 1)) run = 1'b1;
        end
        PH_RESPONSE: begin
          xout    = resp_q;
          phase_d = PH_IDLE;
        end
        PH_READ_RESP: begin
          xout    = resp_q;
          phase_d = PH_READ;
          cnt_d   = '0;
        end
        PH_READ: begin
          priority if (start) begin
            phase_d  = PH_COMMAND;
            cnt_d    = CNT_W'(1);
            frame_we = 1'b1;
          end else if (cnt_q == '0) begin
            xout  = DATA_TOKEN;
            cnt_d = cnt_q + CNT_W'(1);
          end else if ({1'b0, cnt_q} > ({1'b0, blen_q} + (BLK_W+1)'(2))) begin
            cnt_d = '0;
          end else if (cnt_q > blen_q) begin
            cnt_d = cnt_q + CNT_W'(1);
          end else begin
            xout                = req_i.image_byte;
            ptr_d               = ptr_q + 32'd1;
            rsp_d.byte_consumed = 1'b1;
            cnt_d               = cnt_q + CNT_W'(1);
          end
        end
        default: begin
          if (start) begin
            phase_d  = PH_COMMAND;
            cnt_d    = CNT_W'(1);
            frame_we = 1'b1;
          end
        end
      endcase
    end

    if (run) begin
      unique case (cmd)
        CMD_GO_IDLE: begin
          resp_d  = R1_IDLE;
          phase_d = PH_RESPONSE;
        end
        CMD_SEND_OP, CMD_STOP: begin
          resp_d  = R1_READY;
          phase_d = PH_RESPONSE;
        end
        CMD_SET_BLEN: begin
          blen_d  = (arg > 32'(MAX_BLOCK_LEN)) ? BLK_W'(MAX_BLOCK_LEN) : arg[BLK_W-1:0];
          resp_d  = R1_READY;
          phase_d = PH_RESPONSE;
        end
        CMD_READ_MULTI: begin
          ptr_d   = arg;
          resp_d  = R1_READY;
          phase_d = PH_READ_RESP;
        end
        default: phase_d = PH_IDLE;
      endcase
    end

    if (req_i.req_type) begin
      unique case (addr_e'(req_i.addr))
        ADDR_DATA: send_d = req_i.wdata;
        ADDR_XFER: begin
          recv_d = xout;
          send_d = IDLE_BYTE;
        end
        ADDR_CS_ON: begin
          if (!sel_q) phase_d = PH_IDLE;
          sel_d = 1'b1;
        end
        default: sel_d = 1'b0;
      endcase
    end else if (addr_e'(req_i.addr) == ADDR_DATA) begin
      rsp_d.rdata = recv_q;
    end

    rsp_d.read_pointer = ptr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      blen_q  <= BLK_LEN_RST;
      ptr_q   <= '0;
      resp_q  <= IDLE_BYTE;
      send_q  <= IDLE_BYTE;
      recv_q  <= IDLE_BYTE;
      sel_q   <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      blen_q  <= blen_d;
      ptr_q   <= ptr_d;
      resp_q  <= resp_d;
      send_q  <= send_d;
      recv_q  <= recv_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && frame_we) frame_q[frame_idx] <= send_q;
  end

  sdc_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_data_i  (rsp_d),
    .in_ready_o (buf_ready),
    .rsp_o      (rsp_o)
  );

  assign req_i.ready = buf_ready;

`ifndef NO_ASSERTIONS
  a_consume_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && rsp_d.byte_consumed) |-> (phase_q == PH_READ && sel_q))
    else $error("image byte consumed outside a read stream");

  a_stall_needs_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> rsp_o.valid)
    else $error("input stalled with no result pending");

  a_cmd_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_COMMAND) |-> (cnt_q != '0 && cnt_q < CNT_W'(FRAME_LEN)))
    else $error("frame byte count out of range");

  a_blen_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blen_q <= BLK_W'(MAX_BLOCK_LEN))
    else $error("block length above limit");

  a_ptr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && rsp_d.byte_consumed) |=> (ptr_q == $past(ptr_q) + 32'd1))
    else $error("read pointer did not advance by one");
`endif

endmodule

`default_nettype wire

/* src/sdc_out_buf.sv */
`timescale 1ns / 1ps
`default_nettype none

module sdc_out_buf (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire sdc_pkg::rsp_t in_data_i,
  output logic             in_ready_o,
  sdc_rsp_if.source        rsp_o
);
  import sdc_pkg::*;

  logic main_v_q, main_v_d;
  logic skid_v_q, skid_v_d;
  rsp_t main_q, main_d;
  rsp_t skid_q, skid_d;
  logic push, pop;

  assign in_ready_o = !skid_v_q;
  assign push       = in_valid_i && in_ready_o;
  assign pop        = main_v_q && rsp_o.ready;

  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (pop) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end else if (push) begin
        main_d = in_data_i;
      end else begin
        main_v_d = 1'b0;
      end
    end else if (push) begin
      if (!main_v_q) begin
        main_d   = in_data_i;
        main_v_d = 1'b1;
      end else begin
        skid_d   = in_data_i;
        skid_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign rsp_o.valid         = main_v_q;
  assign rsp_o.rdata         = main_q.rdata;
  assign rsp_o.read_pointer  = main_q.read_pointer;
  assign rsp_o.byte_consumed = main_q.byte_consumed;

endmodule

`default_nettype wire
